### hw/rtl/rgi_pkg.sv
// rgi_pkg: shared types and constants of the readability grade block
// holds the channel payload structs, the top grade code and the micro-op table
// of the shared grade adder; no dependencies
package rgi_pkg;

  // input transfer payload
  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_t;

  // output transfer payload
  typedef struct packed {
    logic [4:0]  grade;
    logic [15:0] letters_seen;
    logic [15:0] words_seen;
    logic [15:0] sentences_seen;
  } out_t;

  localparam logic [4:0] GRADE_MAX = 5'd16;

  // operand source of one micro-op
  typedef enum logic [1:0] {
    SRC_L,
    SRC_S,
    SRC_W,
    SRC_D
  } src_t;

  typedef struct packed {
    src_t       src;
    logic [3:0] shift;
    logic       neg;
    logic       clr;
  } op_t;

  // op 2 leaves 100*words in the adder, op 14 leaves N - D
  localparam logic [3:0] OP_D_LOAD = 4'd2;
  localparam logic [3:0] OP_LAST   = 4'd14;

  // shift-and-add program:
  //   100*W, then 588*L - 2960*S - 16*(100*W) - 80*W = N - D
  function automatic op_t op_at(input logic [3:0] idx);
    op_t op;
    case (idx)
      4'd0:    op = '{SRC_W, 4'd6,  1'b0, 1'b1};
      4'd1:    op = '{SRC_W, 4'd5,  1'b0, 1'b0};
      4'd2:    op = '{SRC_W, 4'd2,  1'b0, 1'b0};
      4'd3:    op = '{SRC_L, 4'd9,  1'b0, 1'b1};
      4'd4:    op = '{SRC_L, 4'd6,  1'b0, 1'b0};
      4'd5:    op = '{SRC_L, 4'd3,  1'b0, 1'b0};
      4'd6:    op = '{SRC_L, 4'd2,  1'b0, 1'b0};
      4'd7:    op = '{SRC_S, 4'd11, 1'b1, 1'b0};
      4'd8:    op = '{SRC_S, 4'd9,  1'b1, 1'b0};
      4'd9:    op = '{SRC_S, 4'd8,  1'b1, 1'b0};
      4'd10:   op = '{SRC_S, 4'd7,  1'b1, 1'b0};
      4'd11:   op = '{SRC_S, 4'd4,  1'b1, 1'b0};
      4'd12:   op = '{SRC_D, 4'd4,  1'b1, 1'b0};
      4'd13:   op = '{SRC_W, 4'd6,  1'b1, 1'b0};
      4'd14:   op = '{SRC_W, 4'd4,  1'b1, 1'b0};
      default: op = '{SRC_L, 4'd0,  1'b0, 1'b0};
    endcase
    return op;
  endfunction

endpackage

### hw/rtl/rgi_tally.sv
// rgi_tally: byte classifier and saturating letter, whitespace and stop counters
// presents the counts including the current byte for the grade unit
// depends on rgi_pkg
module rgi_tally import rgi_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_en,
  input  in_t                    in_item,
  output logic [COUNT_WIDTH-1:0] letters,
  output logic [COUNT_WIDTH-1:0] words,
  output logic [COUNT_WIDTH-1:0] stops
);

  logic [COUNT_WIDTH-1:0] letter_tally;
  logic [COUNT_WIDTH-1:0] space_tally;
  logic [COUNT_WIDTH-1:0] stop_tally;
  logic [COUNT_WIDTH-1:0] letter_next;
  logic [COUNT_WIDTH-1:0] space_next;
  logic [COUNT_WIDTH-1:0] stop_next;
  logic                   is_letter;
  logic                   is_space;
  logic                   is_stop;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // byte classes
  always_comb begin
    is_letter = in_item.text_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    is_space  = in_item.text_byte inside {8'h20, [8'h09:8'h0D]};
    is_stop   = in_item.text_byte inside {8'h2E, 8'h21, 8'h3F};
  end

  // counts after this byte
  always_comb begin
    letter_next = is_letter ? sat_inc(letter_tally) : letter_tally;
    space_next  = is_space  ? sat_inc(space_tally)  : space_tally;
    stop_next   = is_stop   ? sat_inc(stop_tally)   : stop_tally;
  end

  assign letters = letter_next;
  assign words   = sat_inc(space_next);
  assign stops   = stop_next;

  // counters, cleared after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      letter_tally <= '0;
      space_tally  <= '0;
      stop_tally   <= '0;
    end else if (byte_en) begin
      if (in_item.final_byte) begin
        letter_tally <= '0;
        space_tally  <= '0;
        stop_tally   <= '0;
      end else begin
        letter_tally <= letter_next;
        space_tally  <= space_next;
        stop_tally   <= stop_next;
      end
    end
  end

endmodule

### hw/rtl/rgi_grade.sv
// rgi_grade: grade unit built around one shared add/subtract datapath
// runs the shift-and-add program, then a threshold search for the grade
// depends on rgi_pkg
module rgi_grade import rgi_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [COUNT_WIDTH-1:0] letters,
  input  logic [COUNT_WIDTH-1:0] words,
  input  logic [COUNT_WIDTH-1:0] stops,
  input  logic                   take,
  output logic                   busy,
  output logic                   done,
  output out_t                   result
);

  localparam int ACC_W = COUNT_WIDTH + 14;
  localparam int DW    = COUNT_WIDTH + 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD,
    ST_SIGN,
    ST_SEARCH,
    ST_DONE
  } state_t;

  state_t                 state;
  logic [COUNT_WIDTH-1:0] l_reg;
  logic [COUNT_WIDTH-1:0] s_reg;
  logic [COUNT_WIDTH-1:0] w_reg;
  logic [DW-1:0]          d_reg;
  logic [ACC_W-1:0]       acc;
  logic [3:0]             op_idx;
  logic [4:0]             grade;
  logic                   first;

  op_t                    op;
  logic [DW-1:0]          src_val;
  logic [ACC_W-1:0]       opnd;
  logic [ACC_W-1:0]       base;
  logic                   neg;
  logic [ACC_W-1:0]       sum;
  logic [31:0]            l_ext;
  logic [31:0]            w_ext;
  logic [31:0]            s_ext;

  // operand select for the shared adder
  always_comb begin
    op = op_at(op_idx);
    case (op.src)
      SRC_L:   src_val = DW'(l_reg);
      SRC_S:   src_val = DW'(s_reg);
      SRC_W:   src_val = DW'(w_reg);
      SRC_D:   src_val = d_reg;
      default: src_val = '0;
    endcase
    if (state == ST_SEARCH) begin
      opnd = first ? ACC_W'(d_reg >> 1) : ACC_W'(d_reg);
      base = acc;
      neg  = 1'b1;
    end else begin
      opnd = ACC_W'(src_val) << op.shift;
      base = op.clr ? '0 : acc;
      neg  = op.neg;
    end
  end

  // shared adder
  assign sum = base + (neg ? ~opnd : opnd) + ACC_W'(neg);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      op_idx <= '0;
      grade  <= '0;
      first  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            l_reg  <= letters;
            s_reg  <= stops;
            w_reg  <= words;
            op_idx <= '0;
            state  <= ST_BUILD;
          end
        end
        ST_BUILD: begin
          acc <= sum;
          if (op_idx == OP_D_LOAD) begin
            d_reg <= sum[DW-1:0];
          end
          if (op_idx == OP_LAST) begin
            state <= ST_SIGN;
          end else begin
            op_idx <= op_idx + 4'd1;
          end
        end
        ST_SIGN: begin
          // acc holds N - D
          if (acc[ACC_W-1]) begin
            grade <= '0;
            state <= ST_DONE;
          end else begin
            grade <= 5'd1;
            first <= 1'b1;
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (sum[ACC_W-1] || grade == GRADE_MAX) begin
            state <= ST_DONE;
          end else begin
            grade <= grade + 5'd1;
            acc   <= sum;
            first <= 1'b0;
          end
        end
        ST_DONE: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

  // reported counts are the low bits of the counters
  assign l_ext = 32'(l_reg);
  assign w_ext = 32'(w_reg);
  assign s_ext = 32'(s_reg);

  always_comb begin
    result.grade          = grade;
    result.letters_seen   = l_ext[15:0];
    result.words_seen     = w_ext[15:0];
    result.sentences_seen = s_ext[15:0];
  end

endmodule

### hw/rtl/readability_grade_index.sv
// readability_grade_index: Coleman-Liau grade of a byte stream, top level
// instantiates rgi_tally and rgi_grade; depends on rgi_pkg

// Bytes of a text arrive one per transfer; an ordinary byte is taken whenever
// the grade unit is idle and bytes stream back to back. The byte marked final
// starts the grade unit, and in_ready stays low (longer while the previous
// result still waits in the output register) while one shared adder runs a
// 15-step shift-and-add program (588*letters - 2960*stops - 1680*words), one
// sign check and then a threshold search of up to 16 steps that yields the
// grade 0..16. The result, with the three counts (low 16 bits, counters
// saturate), sits in an output register until transferred, and the counters
// restart at zero for the next text.
module readability_grade_index import rgi_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic                   in_xfer;
  logic                   start;
  logic [COUNT_WIDTH-1:0] letters;
  logic [COUNT_WIDTH-1:0] words;
  logic [COUNT_WIDTH-1:0] stops;
  logic                   gr_busy;
  logic                   gr_done;
  logic                   take;
  out_t                   gr_result;

  assign in_ready = !gr_busy;
  assign in_xfer  = in_valid && in_ready;
  assign start    = in_xfer && in_data.final_byte;

  rgi_tally #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_tally (
    .clk    (clk),
    .rst    (rst),
    .byte_en(in_xfer),
    .in_item(in_data),
    .letters(letters),
    .words  (words),
    .stops  (stops)
  );

  rgi_grade #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_grade (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .letters(letters),
    .words  (words),
    .stops  (stops),
    .take   (take),
    .busy   (gr_busy),
    .done   (gr_done),
    .result (gr_result)
  );

  // output register
  assign take = gr_done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
      out_data  <= gr_result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // final byte starts the grade unit, which holds off further input
  a_final_blocks: assert property (@(posedge clk) disable iff (rst)
    start |=> !in_ready)
    else $error("input still ready after final byte transfer");

  // finished grade is held until the output register takes it
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (gr_done && !take) |=> gr_done)
    else $error("grade result dropped before handoff");

  // grade stays within 0..16
  a_grade_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.grade <= GRADE_MAX))
    else $error("grade out of range");

  // a handoff always raises out_valid
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("output register missed a result");

endmodule

### test/rgi_grade_checker.sv
// rgi_grade_checker: watches both channels of readability_grade_index and
// predicts each Coleman-Liau grade from its own byte counts, then compares
// depends on rgi_pkg for the payload types and the top grade code
`timescale 1ns / 100ps

module rgi_grade_checker import rgi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   mismatches,
  output int   pending
);

  localparam logic [15:0] TALLY_MAX = 16'hFFFF;

  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_BANG     = 8'h21;
  localparam logic [7:0] CH_PERIOD   = 8'h2E;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;

  logic [15:0] letter_run;
  logic [15:0] space_run;
  logic [15:0] stop_run;
  out_t        grades_due [$];

  // counters hold at all ones
  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == TALLY_MAX) ? v : v + 16'd1;
  endfunction

  // exact integer form of 0.0588*L - 0.296*S - 15.8, per 100 words
  function automatic logic [4:0] coleman_liau_grade(input logic [15:0] letters,
                                                    input logic [15:0] words,
                                                    input logic [15:0] stops);
    longint num;
    longint den;
    num = 588 * longint'(letters) - 2960 * longint'(stops) - 1580 * longint'(words);
    den = 100 * longint'(words);
    if (num >= 16 * den) return GRADE_MAX;
    if (num < den) return 5'd0;
    return 5'((num + den / 2) / den);
  endfunction

  function automatic int field_differs(input string name, input logic [15:0] want_v,
                                       input logic [15:0] got_v);
    if (got_v === want_v) return 0;
    $error("%s expected %0d actual %0d", name, want_v, got_v);
    return 1;
  endfunction

  // result side first: a result leaving this cycle never belongs to a
  // final byte taken in the same cycle
  always @(posedge clk) begin : track
    out_t        want;
    logic [7:0]  b;
    logic [15:0] words;
    if (rst) begin
      letter_run = '0;
      space_run  = '0;
      stop_run   = '0;
      grades_due.delete();
      pending <= 0;
    end else begin
      // compare a result transfer with the oldest text
      if (out_valid && out_ready) begin
        if (grades_due.size() == 0) begin
          $error("result with no text pending, grade actual %0d", out_data.grade);
          mismatches++;
        end else begin
          want = grades_due.pop_front();
          mismatches += field_differs("grade", 16'(want.grade), 16'(out_data.grade))
                      + field_differs("letters_seen", want.letters_seen,
                                      out_data.letters_seen)
                      + field_differs("words_seen", want.words_seen, out_data.words_seen)
                      + field_differs("sentences_seen", want.sentences_seen,
                                      out_data.sentences_seen);
        end
      end

      // count a byte transfer, close the text on the final byte
      if (in_valid && in_ready) begin
        b = in_data.text_byte;
        if ((b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b >= CH_LOWER_A && b <= CH_LOWER_Z))
          letter_run = bump(letter_run);
        else if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
          space_run = bump(space_run);
        else if (b == CH_PERIOD || b == CH_BANG || b == CH_QUESTION)
          stop_run = bump(stop_run);

        if (in_data.final_byte) begin
          words               = bump(space_run);
          want.grade          = coleman_liau_grade(letter_run, words, stop_run);
          want.letters_seen   = letter_run;
          want.words_seen     = words;
          want.sentences_seen = stop_run;
          grades_due.push_back(want);
          letter_run = '0;
          space_run  = '0;
          stop_run   = '0;
        end
      end
      pending <= grades_due.size();
    end
  end

endmodule

### test/tb_readability_grade_index.sv
// tb_readability_grade_index: drives text bytes into readability_grade_index
// under random idling and back-pressure; rgi_grade_checker does the checking
// depends on rgi_pkg, readability_grade_index and rgi_grade_checker
`timescale 1ns / 100ps

module tb_readability_grade_index;
  import rgi_pkg::*;

  localparam int RANDOM_ITEMS = 850;
  localparam int IDLE_PCT     = 9;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 50;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_BANG     = 8'h21;
  localparam logic [7:0] CH_PERIOD   = 8'h2E;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;

  // class boundaries: neighbors of each letter range and of the whitespace
  // range, comma, DEL, high bytes and all three stops
  localparam logic [7:0] BOUNDARY_TEXT [20] = '{
    8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B,
    8'h08, 8'h09, 8'h0D, 8'h0E, 8'h20, 8'h2C, 8'h7F, 8'h80,
    8'hFF, 8'h2E, 8'h21, 8'h3F
  };

  logic clk;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int   mismatches;
  int   pending;
  int   cycle_count   = 0;
  bit   calm          = 1'b0;
  bit   long_hold_req = 1'b0;
  bit   long_hold_done = 1'b0;

  readability_grade_index DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  rgi_grade_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // run limit
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // offer one byte, with an occasional one-cycle gap before it, until transferred
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{text_byte: b, final_byte: fin};
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering until every graded text has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // words of letters, a stop after some words, whitespace between, noise mixed in
  task automatic send_text(input int len, input int word_max, input int stop_odds,
                           input int noise_pct);
    int         word_left;
    bit         stopped;
    logic [7:0] b;
    word_left = $urandom_range(1, word_max);
    stopped   = 1'b0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        b = 8'($urandom_range(0, 255));
      end else if (word_left > 0) begin
        b = ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'($urandom_range(0, 25));
        word_left--;
      end else if (!stopped && $urandom_range(0, 7) < stop_odds) begin
        case ($urandom_range(0, 2))
          0:       b = CH_PERIOD;
          1:       b = CH_BANG;
          default: b = CH_QUESTION;
        endcase
        stopped = 1'b1;
      end else begin
        b = ($urandom_range(0, 3) != 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
        word_left = $urandom_range(1, word_max);
        stopped   = 1'b0;
      end
      send_byte(b, i == len - 1);
    end
  endtask

  // stimulus and verdict
  initial begin : stimulus
    int sent;
    int text_no;
    int len;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // lone NUL byte as the whole text
    send_byte(CH_NUL, 1'b1);
    // class boundaries, final byte is a stop
    foreach (BOUNDARY_TEXT[i])
      send_byte(BOUNDARY_TEXT[i], i == $size(BOUNDARY_TEXT) - 1);
    // one long word: top grade
    send_byte(CH_UPPER_A, 1'b0);
    for (int i = 1; i < 6; i++)
      send_byte(CH_LOWER_A + 8'(i), i == 5);
    wait_for_results();

    // random texts
    sent    = 0;
    text_no = 0;
    while (sent < RANDOM_ITEMS) begin
      if (text_no == 4)
        long_hold_req = 1'b1;
      calm = (text_no >= 12 && text_no < 24);
      if (text_no == 20)
        wait_for_results();
      len = $urandom_range(1, 40);
      if ($urandom_range(0, 99) < 15)
        send_text(len, 2, 0, 100);
      else
        send_text(len, $urandom_range(2, 12), $urandom_range(0, 4), $urandom_range(0, 10));
      sent += len;
      text_no++;
    end
    calm = 1'b0;

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
